/* hw/rtl/e2q_pkg.sv */
// Shared constants and helpers for the Euler-to-quaternion block.
// Holds the Q30 angle constants and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package e2q_pkg;

  // Q30 constants: half pi and pi in radians, and the CORDIC gain.
  localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [31:0] Q30_GAIN    = 32'sd652032874;

  // The step count never goes past the arctangent table.
  localparam int MAX_STEPS = 32;

  // Width of the internal sine and cosine words and of the residual angle.
  localparam int TRIG_WIDTH = 32;
  localparam int RESID_WIDTH = 33;

  typedef logic signed [TRIG_WIDTH-1:0] trig_t;
  typedef logic signed [RESID_WIDTH-1:0] resid_t;

  // atan(2^-i) in Q30, truncated.
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] val;
    unique case (idx)
      5'd0:  val = 30'd843314856;
      5'd1:  val = 30'd497837829;
      5'd2:  val = 30'd263043836;
      5'd3:  val = 30'd133525158;
      5'd4:  val = 30'd67021686;
      5'd5:  val = 30'd33543515;
      5'd6:  val = 30'd16775850;
      5'd7:  val = 30'd8388437;
      5'd8:  val = 30'd4194282;
      5'd9:  val = 30'd2097149;
      5'd10: val = 30'd1048575;
      5'd11: val = 30'd524287;
      5'd12: val = 30'd262143;
      5'd13: val = 30'd131071;
      5'd14: val = 30'd65535;
      5'd15: val = 30'd32767;
      5'd16: val = 30'd16383;
      5'd17: val = 30'd8191;
      5'd18: val = 30'd4095;
      5'd19: val = 30'd2047;
      5'd20: val = 30'd1023;
      5'd21: val = 30'd511;
      5'd22: val = 30'd255;
      5'd23: val = 30'd127;
      5'd24: val = 30'd63;
      5'd25: val = 30'd31;
      5'd26: val = 30'd15;
      5'd27: val = 30'd7;
      5'd28: val = 30'd3;
      5'd29: val = 30'd1;
      default: val = 30'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/euler_to_quaternion_top.sv */
// Euler angles (roll, pitch, yaw) to unit quaternion, fully pipelined.
// Stages: fold, one stage per CORDIC iteration, pair products, roll products,
// sum and saturate. Throughput: one word per cycle while out_stall is low, set
// by the per-stage CORDIC pipeline; stalls only fill bubbles.
// Reset clears the stage valid bits only; the data path is not reset.
`default_nettype none

module euler_to_quaternion_top import e2q_pkg::*; #(
  parameter int ANGLE_WIDTH  = 16,
  parameter int QUAT_WIDTH   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_roll_angle,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_pitch_angle,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_yaw_angle,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [QUAT_WIDTH-1:0]       out_quat_x,
  output logic signed [QUAT_WIDTH-1:0]       out_quat_y,
  output logic signed [QUAT_WIDTH-1:0]       out_quat_z,
  output logic signed [QUAT_WIDTH-1:0]       out_quat_w
);

  localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int NST = STEPS + 4;
  localparam int QONE = 1 << (QUAT_WIDTH - 2);

  logic [NST-1:0] vld_r, vld_nxt, adv;
  trig_t sr, cr, sp, cp, sy, cy;

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    adv[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  // Valid bits follow the words down the pipeline.
  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NST; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NST-1];

  // Three angle lanes side by side.
  e2q_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(STEPS)) u_roll (
    .clk(clk), .stage_en(adv[STEPS:0]), .angle(in_roll_angle),
    .sin_o(sr), .cos_o(cr)
  );

  e2q_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(STEPS)) u_pitch (
    .clk(clk), .stage_en(adv[STEPS:0]), .angle(in_pitch_angle),
    .sin_o(sp), .cos_o(cp)
  );

  e2q_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(STEPS)) u_yaw (
    .clk(clk), .stage_en(adv[STEPS:0]), .angle(in_yaw_angle),
    .sin_o(sy), .cos_o(cy)
  );

  // Merge the lanes into the quaternion.
  e2q_merge #(.QUAT_WIDTH(QUAT_WIDTH)) u_merge (
    .clk(clk), .stage_en(adv[NST-1:STEPS+1]),
    .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
    .quat_x(out_quat_x), .quat_y(out_quat_y),
    .quat_z(out_quat_z), .quat_w(out_quat_w)
  );

  // The input only stalls when the first stage holds a word that cannot move.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> vld_r[0])
    else $error("input stalled with an empty first stage");

  // A stalled output word keeps the whole pipeline from dropping it.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !adv[NST-1])
    else $error("output stage advanced while stalled");

  // Every delivered w and x component lies within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_quat_w) <= QONE && $signed(out_quat_w) >= -QONE &&
                   $signed(out_quat_x) <= QONE && $signed(out_quat_x) >= -QONE))
    else $error("quaternion component out of range");

endmodule

`default_nettype wire

/* hw/rtl/e2q_lane.sv */
// One angle lane: halves the angle, folds it into +-pi/2 and runs a
// pipelined rotation-mode CORDIC, one iteration per stage. Uses e2q_pkg.
`default_nettype none

module e2q_lane import e2q_pkg::*; #(
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                          clk,
  input  wire logic [CORDIC_STEPS:0]         stage_en,
  input  wire logic signed [ANGLE_WIDTH-1:0] angle,
  output trig_t                              sin_o,
  output trig_t                              cos_o
);

  localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  trig_t  x_r    [STEPS+1];
  trig_t  y_r    [STEPS+1];
  resid_t z_r    [STEPS+1];
  logic   flip_r [STEPS+1];

  logic signed [33:0] half_ang;
  resid_t             fold_z;
  logic               fold_flip;

  // The halved angle in Q30, then the quadrant fold.
  always_comb begin
    half_ang  = 34'(angle) <<< (32 - ANGLE_WIDTH);
    fold_flip = 1'b0;
    fold_z    = RESID_WIDTH'(half_ang);
    if (half_ang > Q30_HALF_PI) begin
      fold_z    = RESID_WIDTH'(half_ang - Q30_PI);
      fold_flip = 1'b1;
    end else if (half_ang < -Q30_HALF_PI) begin
      fold_z    = RESID_WIDTH'(half_ang + Q30_PI);
      fold_flip = 1'b1;
    end
  end

  // Fold stage loads the CORDIC start vector.
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      x_r[0]    <= Q30_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= fold_z;
      flip_r[0] <= fold_flip;
    end
  end

  // One CORDIC iteration per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    trig_t  dx;
    trig_t  dy;
    resid_t ang;
    assign dx  = y_r[i] >>> i;
    assign dy  = x_r[i] >>> i;
    assign ang = RESID_WIDTH'(atan_q30(5'(i)));

    always_ff @(posedge clk) begin
      if (stage_en[i+1]) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][RESID_WIDTH-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ang;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ang;
        end
      end
    end
  end

  // Undo the quadrant fold.
  assign cos_o = flip_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
  assign sin_o = flip_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];

endmodule

`default_nettype wire

/* hw/rtl/e2q_merge.sv */
// Merge stage: combines the three lanes' sines and cosines into the
// quaternion over three registered stages. Uses e2q_pkg.
`default_nettype none

module e2q_merge import e2q_pkg::*; #(
  parameter int QUAT_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic [2:0]             stage_en,
  input  wire trig_t                  sr,
  input  wire trig_t                  cr,
  input  wire trig_t                  sp,
  input  wire trig_t                  cp,
  input  wire trig_t                  sy,
  input  wire trig_t                  cy,
  output logic signed [QUAT_WIDTH-1:0] quat_x,
  output logic signed [QUAT_WIDTH-1:0] quat_y,
  output logic signed [QUAT_WIDTH-1:0] quat_z,
  output logic signed [QUAT_WIDTH-1:0] quat_w
);

  localparam int OUT_SHIFT = 62 - QUAT_WIDTH;
  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (OUT_SHIFT - 1);
  localparam logic signed [63:0] Q_ONE      = 64'sd1 <<< (QUAT_WIDTH - 2);
  localparam logic signed [63:0] PAIR_HALF  = 64'sd1 <<< 29;

  // Round Q60 to the output format and clamp to +-1.0.
  function automatic logic [QUAT_WIDTH-1:0] to_quat(input logic signed [63:0] q60);
    logic signed [63:0] v;
    v = (q60 + ROUND_HALF) >>> OUT_SHIFT;
    if (v > Q_ONE) begin
      v = Q_ONE;
    end else if (v < -Q_ONE) begin
      v = -Q_ONE;
    end
    return v[QUAT_WIDTH-1:0];
  endfunction

  logic signed [63:0] p_cpcy, p_spsy, p_cpsy, p_spcy;
  trig_t cpcy_r, spsy_r, cpsy_r, spcy_r, sr_r, cr_r;
  logic signed [63:0] t_r [8];
  logic signed [63:0] t_cmb [8];

  // Pair products of pitch and yaw, rounded back to Q30.
  assign p_cpcy = (cp * cy + PAIR_HALF) >>> 30;
  assign p_spsy = (sp * sy + PAIR_HALF) >>> 30;
  assign p_cpsy = (cp * sy + PAIR_HALF) >>> 30;
  assign p_spcy = (sp * cy + PAIR_HALF) >>> 30;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      cpcy_r <= p_cpcy[TRIG_WIDTH-1:0];
      spsy_r <= p_spsy[TRIG_WIDTH-1:0];
      cpsy_r <= p_cpsy[TRIG_WIDTH-1:0];
      spcy_r <= p_spcy[TRIG_WIDTH-1:0];
      sr_r   <= sr;
      cr_r   <= cr;
    end
  end

  // Roll terms, kept at full Q60.
  assign t_cmb[0] = sr_r * cpcy_r;
  assign t_cmb[1] = cr_r * spsy_r;
  assign t_cmb[2] = cr_r * spcy_r;
  assign t_cmb[3] = sr_r * cpsy_r;
  assign t_cmb[4] = cr_r * cpsy_r;
  assign t_cmb[5] = sr_r * spcy_r;
  assign t_cmb[6] = cr_r * cpcy_r;
  assign t_cmb[7] = sr_r * spsy_r;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      t_r <= t_cmb;
    end
  end

  // Sum, round and saturate into the output word.
  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      quat_x <= to_quat(t_r[0] - t_r[1]);
      quat_y <= to_quat(t_r[2] + t_r[3]);
      quat_z <= to_quat(t_r[4] - t_r[5]);
      quat_w <= to_quat(t_r[6] + t_r[7]);
    end
  end

endmodule

`default_nettype wire
